// ===== rtl/core/saabb_pkg.sv =====
package saabb_pkg;

  localparam int AXES     = 3;
  localparam int COORD_W  = 32;
  localparam int HALF_W   = 31;
  localparam int BOUND_W  = COORD_W + 1;
  localparam int DIFF_W   = COORD_W + 2;
  localparam int FRAC_W   = 32;
  localparam int PROD_W   = 2 * FRAC_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [HALF_W-1:0]  half_t;
  typedef logic signed [BOUND_W-1:0] bound_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic        [FRAC_W-1:0]  frac_t;
  typedef logic        [PROD_W-1:0]  prod_t;

endpackage

// ===== rtl/core/saabb_if.sv =====
interface saabb_in_if import saabb_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;
  coord_t center_x;
  coord_t center_y;
  coord_t center_z;
  half_t  half_x;
  half_t  half_y;
  half_t  half_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, end_x, end_y, end_z,
           center_x, center_y, center_z, half_x, half_y, half_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, end_x, end_y, end_z,
           center_x, center_y, center_z, half_x, half_y, half_z,
    output ready
  );
endinterface

interface saabb_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// ===== rtl/core/segment_aabb_intersection.sv =====
// segment versus axis-aligned box test (slab method), fully pipelined.
// a request carries a segment (origin, end) and a box (center, half extent)
// in Q16.16; the result is one hit bit, set when the segment touches the
// closed box (grazing a face, edge or corner counts). one request is taken
// every cycle while the pipe can advance: stage 1 forms the
// 33-bit box bounds, stage 2 the reject flag and per-axis entry/exit
// fractions, stage 3 the eighteen 32x32 cross products, stage 4 the exact
// compares. when the result side stalls, full stages hold in place and
// bubbles are squeezed out, so in_req.ready stays high while out_res.ready is.
module segment_aabb_intersection import saabb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  saabb_in_if.sink        in_req,
  saabb_out_if.source     out_res
);

  // stage advance enables, from the output backwards
  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;

  assign en4 = !v4_r || out_res.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_req.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_req.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // input unpacking per axis
  coord_t in_o [AXES];
  coord_t in_e [AXES];
  coord_t in_c [AXES];
  half_t  in_h [AXES];

  assign in_o[0] = in_req.origin_x;
  assign in_o[1] = in_req.origin_y;
  assign in_o[2] = in_req.origin_z;
  assign in_e[0] = in_req.end_x;
  assign in_e[1] = in_req.end_y;
  assign in_e[2] = in_req.end_z;
  assign in_c[0] = in_req.center_x;
  assign in_c[1] = in_req.center_y;
  assign in_c[2] = in_req.center_z;
  assign in_h[0] = in_req.half_x;
  assign in_h[1] = in_req.half_y;
  assign in_h[2] = in_req.half_z;

  // stage 1: box bounds at 33 bits, never wraps
  coord_t o1_r  [AXES];
  coord_t e1_r  [AXES];
  bound_t mn1_r [AXES];
  bound_t mx1_r [AXES];

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int a = 0; a < AXES; a++) begin
        o1_r[a]  <= in_o[a];
        e1_r[a]  <= in_e[a];
        mn1_r[a] <= {in_c[a][COORD_W-1], in_c[a]} - {2'b00, in_h[a]};
        mx1_r[a] <= {in_c[a][COORD_W-1], in_c[a]} + {2'b00, in_h[a]};
      end
    end
  end

  // stage 2: outright reject and entry/exit fractions per axis
  logic  rej_nxt;
  frac_t sn_nxt [AXES];
  frac_t sd_nxt [AXES];
  frac_t xn_nxt [AXES];
  frac_t xd_nxt [AXES];

  always_comb begin
    diff_t o, e, mn, mx, d;
    rej_nxt = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      o  = DIFF_W'(o1_r[a]);
      e  = DIFF_W'(e1_r[a]);
      mn = DIFF_W'(mn1_r[a]);
      mx = DIFF_W'(mx1_r[a]);
      sn_nxt[a] = '0;
      sd_nxt[a] = FRAC_W'(1);
      xn_nxt[a] = FRAC_W'(1);
      xd_nxt[a] = FRAC_W'(1);
      if (o < e) begin
        d = e - o;
        if (o > mx || e < mn) rej_nxt = 1'b1;
        if (o < mn) begin
          sn_nxt[a] = FRAC_W'(mn - o);
          sd_nxt[a] = FRAC_W'(d);
        end
        if (e > mx) begin
          xn_nxt[a] = FRAC_W'(mx - o);
          xd_nxt[a] = FRAC_W'(d);
        end
      end else begin
        d = o - e;
        if (e > mx || o < mn) rej_nxt = 1'b1;
        if (o > mx) begin
          sn_nxt[a] = FRAC_W'(o - mx);
          sd_nxt[a] = FRAC_W'(d);
        end
        if (e < mn) begin
          xn_nxt[a] = FRAC_W'(o - mn);
          xd_nxt[a] = FRAC_W'(d);
        end
      end
    end
  end

  logic  rej2_r;
  frac_t sn2_r [AXES];
  frac_t sd2_r [AXES];
  frac_t xn2_r [AXES];
  frac_t xd2_r [AXES];

  always_ff @(posedge clk) begin
    if (en2) begin
      rej2_r <= rej_nxt;
      sn2_r  <= sn_nxt;
      sd2_r  <= sd_nxt;
      xn2_r  <= xn_nxt;
      xd2_r  <= xd_nxt;
    end
  end

  // stage 3: entry i against exit j, cross multiplied
  logic  rej3_r;
  prod_t pl3_r [AXES][AXES];
  prod_t pr3_r [AXES][AXES];

  always_ff @(posedge clk) begin
    if (en3) begin
      rej3_r <= rej2_r;
      for (int i = 0; i < AXES; i++) begin
        for (int j = 0; j < AXES; j++) begin
          pl3_r[i][j] <= PROD_W'(sn2_r[i]) * PROD_W'(xd2_r[j]);
          pr3_r[i][j] <= PROD_W'(xn2_r[j]) * PROD_W'(sd2_r[i]);
        end
      end
    end
  end

  // stage 4: hit when no axis rejects and every entry is at most every exit
  logic hit_nxt;
  logic hit4_r;

  always_comb begin
    hit_nxt = !rej3_r;
    for (int i = 0; i < AXES; i++) begin
      for (int j = 0; j < AXES; j++) begin
        if (pl3_r[i][j] > pr3_r[i][j]) hit_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4) hit4_r <= hit_nxt;
  end

  assign out_res.valid = v4_r;
  assign out_res.hit   = hit4_r;

`ifndef NO_ASSERTIONS
  // a free result side never throttles requests
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.ready |-> in_req.ready)
    else $error("request side stalled while result side is free");

  // an outright reject always yields a miss
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && en4 && rej3_r) |=> (v4_r && !out_res.hit))
    else $error("rejected pair reported as hit");

  // the pipe only fills from an accepted request
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (en1 && !in_req.valid) |=> !v1_r)
    else $error("stage 1 valid without request");
`endif

endmodule

// ===== sim/tb_saabb_if.sv =====
`timescale 1ns / 1ps

// the block's channel interfaces (saabb_in_if, saabb_out_if) come with the rtl;
// this file carries the request item type that stimulus and checker share
package tb_saabb_pkg;
  import saabb_pkg::*;

  typedef struct packed {
    coord_t origin_x, origin_y, origin_z;
    coord_t end_x, end_y, end_z;
    coord_t center_x, center_y, center_z;
    half_t  half_x, half_y, half_z;
  } seg_box_t;
endpackage

// ===== sim/saabb_checker.sv =====
`timescale 1ns / 1ps

module saabb_checker import saabb_pkg::*; import tb_saabb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  saabb_in_if        in_req,
  saabb_out_if       out_res,
  output int         fail_count,
  output int         pending_hits
);

  bit expected_hits[$];

  // sign of an/ad - bn/bd with positive denominators
  function automatic int ratio_order(longint unsigned an, longint unsigned ad,
                                     longint unsigned bn, longint unsigned bd);
    logic [127:0] l, r;
    l = 128'(an) * 128'(bd);
    r = 128'(bn) * 128'(ad);
    if (l > r) return 1;
    if (l < r) return -1;
    return 0;
  endfunction

  function automatic bit slab_hit(seg_box_t s);
    longint o[3], e[3], c[3], h[3];
    longint mn, mx;
    longint unsigned en_n, en_d, ex_n, ex_d, sn, sd, xn, xd, d;
    o = '{longint'(s.origin_x), longint'(s.origin_y), longint'(s.origin_z)};
    e = '{longint'(s.end_x), longint'(s.end_y), longint'(s.end_z)};
    c = '{longint'(s.center_x), longint'(s.center_y), longint'(s.center_z)};
    h = '{longint'({1'b0, s.half_x}), longint'({1'b0, s.half_y}),
          longint'({1'b0, s.half_z})};
    en_n = 0; en_d = 1; ex_n = 1; ex_d = 1;
    for (int ax = 0; ax < AXES; ax++) begin
      mn = c[ax] - h[ax];
      mx = c[ax] + h[ax];
      sn = 0; sd = 1; xn = 1; xd = 1;
      if (o[ax] < e[ax]) begin
        if (o[ax] > mx || e[ax] < mn) return 0;
        d = e[ax] - o[ax];
        if (o[ax] < mn) begin sn = mn - o[ax]; sd = d; end
        if (e[ax] > mx) begin xn = mx - o[ax]; xd = d; end
      end else begin
        if (e[ax] > mx || o[ax] < mn) return 0;
        d = o[ax] - e[ax];
        if (o[ax] > mx) begin sn = o[ax] - mx; sd = d; end
        if (e[ax] < mn) begin xn = o[ax] - mn; xd = d; end
      end
      if (ratio_order(sn, sd, en_n, en_d) > 0) begin en_n = sn; en_d = sd; end
      if (ratio_order(xn, xd, ex_n, ex_d) < 0) begin ex_n = xn; ex_d = xd; end
      if (ratio_order(ex_n, ex_d, en_n, en_d) < 0) return 0;
    end
    return 1;
  endfunction

  seg_box_t req;
  bit want;

  assign req = '{in_req.origin_x, in_req.origin_y, in_req.origin_z,
                 in_req.end_x, in_req.end_y, in_req.end_z,
                 in_req.center_x, in_req.center_y, in_req.center_z,
                 in_req.half_x, in_req.half_y, in_req.half_z};
  assign pending_hits = expected_hits.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual hit=%0b",
                   $time, out_res.hit);
          fail_count++;
        end else begin
          want = expected_hits.pop_front();
          if (out_res.hit !== want) begin
            $display("%0t: hit expected %0b actual %0b", $time, want, out_res.hit);
            fail_count++;
          end
        end
      end
      if (in_req.valid && in_req.ready) expected_hits = {expected_hits, slab_hit(req)};
    end
  end

endmodule

// ===== sim/tb_segment_aabb_intersection.sv =====
`timescale 1ns / 1ps

module tb_segment_aabb_intersection;
  import saabb_pkg::*;
  import tb_saabb_pkg::*;

  localparam int DIRECTED_REQS = 15;
  localparam int RANDOM_REQS = 1800;
  localparam int CALM_TAIL   = 200;   // last requests run with no idling
  localparam int PIPE_DRAIN  = 10;    // four-stage pipe plus margin

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending_hits;
  int   sent;

  saabb_in_if  in_req();
  saabb_out_if out_res();

  segment_aabb_intersection dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_res(out_res.source)
  );

  saabb_checker chk (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_res(out_res),
    .fail_count(fail_count), .pending_hits(pending_hits)
  );

  always #4 clk = ~clk;

  // random coordinate: mostly small values near the box, some full range
  function automatic coord_t any_coord();
    case ($urandom_range(0, 9))
      0:       return coord_t'($urandom());
      1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return coord_t'($signed($urandom_range(0, 400)) - 200) <<< 12;
    endcase
  endfunction

  function automatic half_t any_half();
    case ($urandom_range(0, 9))
      0:       return half_t'($urandom());
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return half_t'($urandom_range(0, 120)) << 12;
    endcase
  endfunction

  // drive one request and hold it until accepted
  task automatic send_request(seg_box_t s, bit calm);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_req.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_req.valid    <= 1;
    in_req.origin_x <= s.origin_x; in_req.origin_y <= s.origin_y;
    in_req.origin_z <= s.origin_z;
    in_req.end_x    <= s.end_x;    in_req.end_y    <= s.end_y;
    in_req.end_z    <= s.end_z;
    in_req.center_x <= s.center_x; in_req.center_y <= s.center_y;
    in_req.center_z <= s.center_z;
    in_req.half_x   <= s.half_x;   in_req.half_y   <= s.half_y;
    in_req.half_z   <= s.half_z;
    do @(posedge clk); while (!in_req.ready);
    sent++;
  endtask

  function automatic seg_box_t make_req(coord_t o, coord_t e, coord_t c, half_t h);
    return '{o, o, o, e, e, e, c, c, c, h, h, h};
  endfunction

  // result side stalls in bursts until the calm tail
  initial begin
    out_res.ready = 0;
    @(posedge rst_n);
    forever begin
      if (sent < DIRECTED_REQS + RANDOM_REQS - CALM_TAIL && $urandom_range(0, 4) == 0) begin
        out_res.ready <= 0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_res.ready <= 1;
      @(posedge clk);
    end
  end

  initial begin
    seg_box_t s;
    bit calm;
    in_req.valid = 0;
    {in_req.origin_x, in_req.origin_y, in_req.origin_z} = '0;
    {in_req.end_x, in_req.end_y, in_req.end_z} = '0;
    {in_req.center_x, in_req.center_y, in_req.center_z} = '0;
    {in_req.half_x, in_req.half_y, in_req.half_z} = '0;
    sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, degenerate segments, grazing contacts, both directions
    send_request(make_req(32'sh80000000, 32'sh7fffffff, 32'sh80000000, '1), 0);
    send_request(make_req(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, '1), 0);
    send_request(make_req(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, '0), 0);
    send_request(make_req(0, 0, 0, '0), 0);                     // point on point
    send_request(make_req(32'sh10000, 32'sh10000, 0, 31'h10000), 0); // point on face
    send_request(make_req(32'sh10001, 32'sh10001, 0, 31'h10000), 0); // just outside
    send_request(make_req(32'sh20000, 32'sh10000, 0, 31'h10000), 0); // end grazes
    send_request(make_req(-32'sh20000, -32'sh10001, 0, 31'h10000), 0);
    send_request(make_req(-32'sh20000, 32'sh20000, 0, 31'h10000), 0);
    send_request(make_req(32'sh20000, -32'sh20000, 0, 31'h10000), 0);
    // diagonal touching one edge: exit equals entry
    send_request('{0, 0, 0, 32'sh40000, 32'sh40000, 0,
                   32'sh30000, 32'sh10000, 0, 31'h10000, 31'h10000, 31'h10000}, 0);
    // diagonal missing an edge by one lsb
    send_request('{0, 0, 0, 32'sh40000, 32'sh40000, 0,
                   32'sh30001, 32'sh10000, 0, 31'h10000, 31'h10000, 31'h10000}, 0);
    // the y axis, then the z axis, rejecting alone
    send_request('{0, 32'sh50000, 0, 0, 32'sh50000, 0, 0, 0, 0, 31'h10000, 31'h10000,
                   31'h10000}, 0);
    send_request('{0, 0, 32'sh50000, 0, 0, 32'sh50000, 0, 0, 0, 31'h10000, 31'h10000,
                   31'h10000}, 0);
    send_request('{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                   32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                   0, 0, 0, '1, '1, '1}, 0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      calm = i >= RANDOM_REQS - CALM_TAIL;
      s.center_x = any_coord(); s.center_y = any_coord(); s.center_z = any_coord();
      s.half_x = any_half(); s.half_y = any_half(); s.half_z = any_half();
      if ($urandom_range(0, 2) != 0) begin
        // segment placed around the box so many runs reach every axis
        s.origin_x = s.center_x + coord_t'($signed($urandom_range(0, 65535) - 32768) <<< 4);
        s.origin_y = s.center_y + coord_t'($signed($urandom_range(0, 65535) - 32768) <<< 4);
        s.origin_z = s.center_z + coord_t'($signed($urandom_range(0, 65535) - 32768) <<< 4);
        s.end_x = s.center_x + coord_t'($signed($urandom_range(0, 65535) - 32768) <<< 4);
        s.end_y = s.center_y + coord_t'($signed($urandom_range(0, 65535) - 32768) <<< 4);
        s.end_z = s.center_z + coord_t'($signed($urandom_range(0, 65535) - 32768) <<< 4);
        if ($urandom_range(0, 7) == 0) s.end_y = s.origin_y;
      end else begin
        s.origin_x = any_coord(); s.origin_y = any_coord(); s.origin_z = any_coord();
        s.end_x = any_coord(); s.end_y = any_coord(); s.end_z = any_coord();
      end
      send_request(s, calm);
    end
    in_req.valid <= 0;

    while (pending_hits != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (fail_count == 0)
      $display("segment_aabb_intersection: match");
    else
      $display("segment_aabb_intersection: mismatch");
    $finish;
  end

  // generous limit on the whole run
  initial begin
    #500000;
    $display("segment_aabb_intersection: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/saabb_pkg.sv
rtl/core/saabb_if.sv
rtl/core/segment_aabb_intersection.sv
sim/tb_saabb_if.sv
sim/saabb_checker.sv
sim/tb_segment_aabb_intersection.sv
